[sv/nearest_bone_binder_unit_macros.svh]
// Assertion macros shared by the checker.
`ifndef NEAREST_BONE_BINDER_UNIT_MACROS_SVH
`define NEAREST_BONE_BINDER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NBB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nearest bone binder check failed");

// Next-cycle implication, disabled during reset.
`define NBB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nearest bone binder check failed");

`endif

[sv/nbb_pkg.sv]
package nbb_pkg;

   localparam int MAX_JOINTS_DEF = 64;
   localparam int COORD_W = 24;
   localparam int POS_W = 3 * COORD_W;
   localparam int DIFF_W = COORD_W + 1;
   localparam int SQ_W = 2 * DIFF_W;
   localparam int LEN_W = 50;
   localparam int REM_W = LEN_W + 1;
   localparam int Q_W = 16;
   localparam int FRAC_W = Q_W + 1;
   localparam int PROD_W = DIFF_W + FRAC_W + 1;
   localparam int NEAR_W = COORD_W + 3;
   localparam int ERR_W = COORD_W + 4;
   localparam int ESQ_W = 2 * ERR_W;
   localparam int DSUM_W = ESQ_W + 2;
   localparam int DIST_W = 52;
   localparam int JIDX_W = 6;
   localparam int PAR_W = 7;
   localparam int CNT_W = 7;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic en;
      logic [JIDX_W-1:0] joint;
      logic [PAR_W-1:0] parent;
   } load_req_type;

endpackage

[sv/nbb_cell.sv]
module nbb_cell #(
   parameter int SIDE_W = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic in_v,
   input  logic [nbb_pkg::REM_W-1:0] in_rem,
   input  logic [nbb_pkg::LEN_W-1:0] in_len,
   input  logic [nbb_pkg::Q_W-1:0] in_q,
   input  logic [SIDE_W-1:0] in_side,
   output logic out_v,
   output logic [nbb_pkg::REM_W-1:0] out_rem,
   output logic [nbb_pkg::LEN_W-1:0] out_len,
   output logic [nbb_pkg::Q_W-1:0] out_q,
   output logic [SIDE_W-1:0] out_side
);
   import nbb_pkg::*;

   logic v_ff;
   logic [REM_W-1:0] rem_ff, rem_in, shifted;
   logic [LEN_W-1:0] len_ff;
   logic [Q_W-1:0] q_ff, q_in;
   logic [SIDE_W-1:0] side_ff;

   always_comb begin
      shifted = {in_rem[REM_W-2:0], 1'b0};
      if (shifted >= {1'b0, in_len}) begin
         rem_in = shifted - {1'b0, in_len};
         q_in = {in_q[Q_W-2:0], 1'b1};
      end else begin
         rem_in = shifted;
         q_in = {in_q[Q_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= in_v;
      end
      rem_ff <= rem_in;
      len_ff <= in_len;
      q_ff <= q_in;
      side_ff <= in_side;
   end

   assign out_v = v_ff;
   assign out_rem = rem_ff;
   assign out_len = len_ff;
   assign out_q = q_ff;
   assign out_side = side_ff;

endmodule

[sv/nbb_table.sv]
module nbb_table #(
   parameter int MAX_JOINTS = nbb_pkg::MAX_JOINTS_DEF,
   parameter int AW = 6
) (
   input  logic clock,
   input  logic reset,
   input  nbb_pkg::load_req_type load,
   input  logic [nbb_pkg::POS_W-1:0] load_pos,
   input  logic [AW-1:0] rd_addr,
   output logic [nbb_pkg::POS_W-1:0] rd_pos,
   output logic [nbb_pkg::POS_W-1:0] rd_tip,
   output logic rd_hc
);
   import nbb_pkg::*;

   logic [POS_W-1:0] pos_mem_ff [MAX_JOINTS];
   logic [POS_W-1:0] tip_mem_ff [MAX_JOINTS];
   logic [MAX_JOINTS-1:0] hc_ff, hc_in;
   logic [POS_W-1:0] rd_pos_ff, rd_tip_ff;
   logic rd_hc_ff;
   logic ji_ok, link;
   logic [AW-1:0] ji_a, par_a;

   always_comb begin
      ji_ok = 32'(load.joint) < MAX_JOINTS;
      ji_a = AW'(load.joint);
      par_a = AW'(load.parent[PAR_W-2:0]);
      link = load.en && ji_ok && !load.parent[PAR_W-1]
         && (load.parent[PAR_W-2:0] < load.joint) && !hc_ff[par_a];
      hc_in = hc_ff;
      if (load.en && ji_ok) begin
         hc_in[ji_a] = 1'b0;
      end
      if (link) begin
         hc_in[par_a] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff <= '0;
      end else begin
         hc_ff <= hc_in;
      end
      rd_hc_ff <= hc_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (load.en && ji_ok) begin
         pos_mem_ff[ji_a] <= load_pos;
      end
      rd_pos_ff <= pos_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (link) begin
         tip_mem_ff[par_a] <= load_pos;
      end
      rd_tip_ff <= tip_mem_ff[rd_addr];
   end

   assign rd_pos = rd_pos_ff;
   assign rd_tip = rd_tip_ff;
   assign rd_hc = rd_hc_ff;

endmodule

[sv/nearest_bone_binder_unit.sv]
// Load beat: busy stays low. Query beat: the joints are read one per cycle and stream
// through a pipelined distance path with a sixteen-cell divider chain; the result strobe
// comes once all min(joint_count, MAX_JOINTS) joints have passed through, and busy is
// high until then. A query with no joints answers on the next cycle. The receiver cannot
// stall. Synchronous reset clears the joint count, the child flags and all control state;
// joint positions are undefined until loaded.
module nearest_bone_binder_unit #(
   parameter int MAX_JOINTS = nbb_pkg::MAX_JOINTS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_opcode,
   input  logic [nbb_pkg::JIDX_W-1:0] req_joint_index,
   input  logic signed [nbb_pkg::PAR_W-1:0] req_parent_index,
   input  logic signed [nbb_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [nbb_pkg::COORD_W-1:0] req_pos_y,
   input  logic signed [nbb_pkg::COORD_W-1:0] req_pos_z,
   output logic rsp_valid,
   output logic [nbb_pkg::JIDX_W-1:0] rsp_bone_index,
   output logic [nbb_pkg::DIST_W-1:0] rsp_distance_sq,
   output logic rsp_no_joints,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [nbb_pkg::CNT_W-1:0] csr_data
);
   import nbb_pkg::*;

   localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int CW = $clog2(MAX_JOINTS + 1);
   localparam int SIDE_W = 3 + AW + POS_W + 3 * DIFF_W;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CW-1:0] n_eff;
   logic accept, issue, iss_last, zero_rsp, fin, take;
   logic [AW-1:0] iss_addr_ff;
   logic [POS_W-1:0] vert_ff;
   load_req_type load;
   logic [POS_W-1:0] rd_pos, rd_tip;
   logic rd_hc;

   logic r_v_ff, r_last_ff;
   logic [AW-1:0] r_idx_ff;

   logic a_v_ff, a_last_ff;
   logic [AW-1:0] a_idx_ff;
   logic [POS_W-1:0] a_pos_ff;
   logic signed [DIFF_W-1:0] a_ab_ff [3], a_w_ff [3], ab_in [3], w_in [3];

   logic b_v_ff, b_last_ff;
   logic [AW-1:0] b_idx_ff;
   logic [POS_W-1:0] b_pos_ff;
   logic signed [DIFF_W-1:0] b_ab_ff [3];
   logic signed [SQ_W-1:0] b_sq_ff [3], b_dp_ff [3];

   logic c_v_ff, c_last_ff;
   logic [AW-1:0] c_idx_ff;
   logic [POS_W-1:0] c_pos_ff;
   logic signed [DIFF_W-1:0] c_ab_ff [3];
   logic [LEN_W-1:0] c_len_ff;
   logic signed [REM_W-1:0] c_dp_ff, len_sum, dp_sum;
   logic zero_t, one_t;

   logic ch_v [17];
   logic [REM_W-1:0] ch_rem [17];
   logic [LEN_W-1:0] ch_len [17];
   logic [Q_W-1:0] ch_q [17];
   logic [SIDE_W-1:0] ch_side [17];

   logic o_zero, o_one, o_last;
   logic [AW-1:0] o_idx;
   logic [POS_W-1:0] o_pos;
   logic [3*DIFF_W-1:0] o_ab;
   logic rnd;

   logic e_v_ff, e_last_ff;
   logic [AW-1:0] e_idx_ff;
   logic [POS_W-1:0] e_pos_ff;
   logic [3*DIFF_W-1:0] e_ab_ff;
   logic [FRAC_W-1:0] e_t_ff, t_in;

   logic f_v_ff, f_last_ff;
   logic [AW-1:0] f_idx_ff;
   logic [POS_W-1:0] f_pos_ff;
   logic signed [PROD_W-1:0] f_prod_ff [3];

   logic g_v_ff, g_last_ff;
   logic [AW-1:0] g_idx_ff;
   logic signed [ERR_W-1:0] g_err_ff [3], err_in [3];

   logic h_v_ff, h_last_ff;
   logic [AW-1:0] h_idx_ff;
   logic [ESQ_W-1:0] h_sq_ff [3];

   logic i_v_ff, i_last_ff;
   logic [AW-1:0] i_idx_ff;
   logic [DIST_W-1:0] i_d_ff, d_in;
   logic [DSUM_W-1:0] dsum;

   logic first_ff;
   logic [DIST_W-1:0] best_ff, best_new;
   logic [AW-1:0] best_idx_ff, best_idx_new;
   logic rsp_valid_ff, rsp_nj_ff;
   logic [JIDX_W-1:0] rsp_bone_ff;
   logic [DIST_W-1:0] rsp_dist_ff;

   assign csr_ready = 1'b1;
   assign busy = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign n_eff = (32'(count_ff) > MAX_JOINTS) ? CW'(MAX_JOINTS) : CW'(count_ff);
   assign iss_last = (CW'(iss_addr_ff) + CW'(1)) == n_eff;
   assign fin = i_v_ff && i_last_ff;

   always_comb begin
      state_in = state_ff;
      issue = 1'b0;
      zero_rsp = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_opcode == OP_QUERY) begin
               if (n_eff == '0) begin
                  zero_rsp = 1'b1;
               end else begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            issue = 1'b1;
            if (iss_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (fin) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         iss_addr_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
         if (state_ff == ST_ISSUE) begin
            iss_addr_ff <= iss_addr_ff + AW'(1);
         end else begin
            iss_addr_ff <= '0;
         end
      end
      if (accept && req_opcode == OP_QUERY) begin
         vert_ff <= {req_pos_z, req_pos_y, req_pos_x};
      end
   end

   assign load.en = accept && req_opcode == OP_LOAD;
   assign load.joint = req_joint_index;
   assign load.parent = req_parent_index;

   nbb_table #(
      .MAX_JOINTS(MAX_JOINTS),
      .AW(AW)
   ) u_table (
      .clock(clock),
      .reset(reset),
      .load(load),
      .load_pos({req_pos_z, req_pos_y, req_pos_x}),
      .rd_addr(iss_addr_ff),
      .rd_pos(rd_pos),
      .rd_tip(rd_tip),
      .rd_hc(rd_hc)
   );

   always_comb begin
      logic [POS_W-1:0] bsel;
      bsel = rd_hc ? rd_tip : rd_pos;
      for (int c = 0; c < 3; c++) begin
         ab_in[c] = DIFF_W'($signed(bsel[c*COORD_W +: COORD_W]))
            - DIFF_W'($signed(rd_pos[c*COORD_W +: COORD_W]));
         w_in[c] = DIFF_W'($signed(vert_ff[c*COORD_W +: COORD_W]))
            - DIFF_W'($signed(rd_pos[c*COORD_W +: COORD_W]));
      end
   end

   always_comb begin
      len_sum = REM_W'(b_sq_ff[0]) + REM_W'(b_sq_ff[1]) + REM_W'(b_sq_ff[2]);
      dp_sum = REM_W'(b_dp_ff[0]) + REM_W'(b_dp_ff[1]) + REM_W'(b_dp_ff[2]);
      zero_t = (c_len_ff == '0) || (c_dp_ff <= 0);
      one_t = !zero_t && ($unsigned(c_dp_ff) >= {1'b0, c_len_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else begin
         r_v_ff <= issue;
         a_v_ff <= r_v_ff;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
      end
      r_idx_ff <= iss_addr_ff;
      r_last_ff <= iss_last;
      a_idx_ff <= r_idx_ff;
      a_last_ff <= r_last_ff;
      a_pos_ff <= rd_pos;
      b_idx_ff <= a_idx_ff;
      b_last_ff <= a_last_ff;
      b_pos_ff <= a_pos_ff;
      c_idx_ff <= b_idx_ff;
      c_last_ff <= b_last_ff;
      c_pos_ff <= b_pos_ff;
      c_len_ff <= LEN_W'(len_sum);
      c_dp_ff <= dp_sum;
      for (int c = 0; c < 3; c++) begin
         a_ab_ff[c] <= ab_in[c];
         a_w_ff[c] <= w_in[c];
         b_ab_ff[c] <= a_ab_ff[c];
         b_sq_ff[c] <= a_ab_ff[c] * a_ab_ff[c];
         b_dp_ff[c] <= a_w_ff[c] * a_ab_ff[c];
         c_ab_ff[c] <= b_ab_ff[c];
      end
   end

   assign ch_v[0] = c_v_ff;
   assign ch_rem[0] = $unsigned(c_dp_ff);
   assign ch_len[0] = c_len_ff;
   assign ch_q[0] = '0;
   assign ch_side[0] = {zero_t, one_t, c_last_ff, c_idx_ff, c_pos_ff,
                        c_ab_ff[2], c_ab_ff[1], c_ab_ff[0]};

   for (genvar k = 0; k < Q_W; k++) begin : g_div
      nbb_cell #(
         .SIDE_W(SIDE_W)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .in_v(ch_v[k]),
         .in_rem(ch_rem[k]),
         .in_len(ch_len[k]),
         .in_q(ch_q[k]),
         .in_side(ch_side[k]),
         .out_v(ch_v[k+1]),
         .out_rem(ch_rem[k+1]),
         .out_len(ch_len[k+1]),
         .out_q(ch_q[k+1]),
         .out_side(ch_side[k+1])
      );
   end

   assign {o_zero, o_one, o_last, o_idx, o_pos, o_ab} = ch_side[Q_W];

   always_comb begin
      rnd = {ch_rem[Q_W][REM_W-2:0], 1'b0} >= {1'b0, ch_len[Q_W]};
      if (o_zero) begin
         t_in = '0;
      end else if (o_one) begin
         t_in = FRAC_W'(1) << Q_W;
      end else begin
         t_in = FRAC_W'(ch_q[Q_W]) + FRAC_W'(rnd);
      end
   end

   always_comb begin
      logic signed [PROD_W-1:0] sh;
      logic signed [NEAR_W-1:0] nv;
      for (int c = 0; c < 3; c++) begin
         sh = (f_prod_ff[c] + PROD_W'(32768)) >>> Q_W;
         nv = NEAR_W'($signed(f_pos_ff[c*COORD_W +: COORD_W])) + $signed(sh[NEAR_W-1:0]);
         err_in[c] = ERR_W'($signed(vert_ff[c*COORD_W +: COORD_W])) - ERR_W'(nv);
      end
      dsum = DSUM_W'(h_sq_ff[0]) + DSUM_W'(h_sq_ff[1]) + DSUM_W'(h_sq_ff[2]);
      d_in = (|dsum[DSUM_W-1:DIST_W]) ? '1 : dsum[DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
         h_v_ff <= 1'b0;
         i_v_ff <= 1'b0;
      end else begin
         e_v_ff <= ch_v[Q_W];
         f_v_ff <= e_v_ff;
         g_v_ff <= f_v_ff;
         h_v_ff <= g_v_ff;
         i_v_ff <= h_v_ff;
      end
      e_last_ff <= o_last;
      e_idx_ff <= o_idx;
      e_pos_ff <= o_pos;
      e_ab_ff <= o_ab;
      e_t_ff <= t_in;
      f_last_ff <= e_last_ff;
      f_idx_ff <= e_idx_ff;
      f_pos_ff <= e_pos_ff;
      g_last_ff <= f_last_ff;
      g_idx_ff <= f_idx_ff;
      h_last_ff <= g_last_ff;
      h_idx_ff <= g_idx_ff;
      i_last_ff <= h_last_ff;
      i_idx_ff <= h_idx_ff;
      i_d_ff <= d_in;
      for (int c = 0; c < 3; c++) begin
         f_prod_ff[c] <= $signed(e_ab_ff[c*DIFF_W +: DIFF_W]) * $signed({1'b0, e_t_ff});
         g_err_ff[c] <= err_in[c];
         h_sq_ff[c] <= g_err_ff[c] * g_err_ff[c];
      end
   end

   always_comb begin
      take = first_ff || (i_d_ff < best_ff);
      best_new = take ? i_d_ff : best_ff;
      best_idx_new = take ? i_idx_ff : best_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= zero_rsp || fin;
         if (accept && req_opcode == OP_QUERY) begin
            first_ff <= 1'b1;
         end else if (i_v_ff) begin
            first_ff <= 1'b0;
         end
      end
      if (i_v_ff) begin
         best_ff <= best_new;
         best_idx_ff <= best_idx_new;
      end
      if (zero_rsp) begin
         rsp_bone_ff <= '0;
         rsp_dist_ff <= '0;
         rsp_nj_ff <= 1'b1;
      end else if (fin) begin
         rsp_bone_ff <= JIDX_W'(best_idx_new);
         rsp_dist_ff <= best_new;
         rsp_nj_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_bone_index = rsp_bone_ff;
   assign rsp_distance_sq = rsp_dist_ff;
   assign rsp_no_joints = rsp_nj_ff;

endmodule

[sv/nbb_checker.sv]
`include "nearest_bone_binder_unit_macros.svh"

module nbb_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_opcode,
   input logic rsp_valid,
   input logic [nbb_pkg::JIDX_W-1:0] rsp_bone_index,
   input logic [nbb_pkg::DIST_W-1:0] rsp_distance_sq,
   input logic rsp_no_joints
);
   import nbb_pkg::*;

   `NBB_ASSERT_NOW(a_empty_zero, rsp_valid && rsp_no_joints, rsp_bone_index == '0 && rsp_distance_sq == '0)
   `NBB_ASSERT_NEXT(a_query_acts, start && !busy && req_opcode == OP_QUERY, busy || rsp_valid)
   `NBB_ASSERT_NEXT(a_load_free, start && !busy && req_opcode == OP_LOAD, !busy)
   `NBB_ASSERT_NOW(a_busy_ends, $fell(busy), rsp_valid && !rsp_no_joints)

endmodule

bind nearest_bone_binder_unit nbb_checker u_nbb_checker (.*);

[test/tb.sv]
module tb;
   import nbb_pkg::*;

   typedef struct {
      logic [JIDX_W-1:0] bone;
      logic [DIST_W-1:0] dist_sq;
      logic              none;
   } bind_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_opcode = OP_LOAD;
   logic [JIDX_W-1:0] req_joint_index = '0;
   logic signed [PAR_W-1:0] req_parent_index = '0;
   logic signed [COORD_W-1:0] req_pos_x = '0;
   logic signed [COORD_W-1:0] req_pos_y = '0;
   logic signed [COORD_W-1:0] req_pos_z = '0;
   logic rsp_valid;
   logic [JIDX_W-1:0] rsp_bone_index;
   logic [DIST_W-1:0] rsp_distance_sq;
   logic rsp_no_joints;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CNT_W-1:0] csr_data = '0;

   longint joint_pos [MAX_JOINTS_DEF][3];
   longint joint_tip [MAX_JOINTS_DEF][3];
   bit     joint_has_child [MAX_JOINTS_DEF];
   int unsigned searched_count;

   bind_result_type pending_binds[$];
   int mismatches = 0;
   int loads_sent = 0;
   int queries_sent = 0;
   int binds_seen = 0;
   int burst_left = 0;

   nearest_bone_binder_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_joint_index(req_joint_index),
      .req_parent_index(req_parent_index), .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y), .req_pos_z(req_pos_z), .rsp_valid(rsp_valid),
      .rsp_bone_index(rsp_bone_index), .rsp_distance_sq(rsp_distance_sq),
      .rsp_no_joints(rsp_no_joints), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   function automatic longint projection_fraction(longint dp, longint len);
      longint unsigned rem;
      longint unsigned q;
      if (len <= 0 || dp <= 0) return 0;
      if (dp >= len) return 65536;
      rem = dp;
      q = 0;
      for (int i = 0; i < 16; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= longint'(len)) begin
            rem = rem - len;
            q = q | 1;
         end
      end
      if (rem * 2 >= longint'(len)) q = q + 1;
      return q;
   endfunction

   function automatic longint unsigned segment_dist_sq(longint p[3], int j);
      longint a[3];
      longint ab[3];
      longint len;
      longint dp;
      longint t;
      longint n;
      longint e;
      longint unsigned d;
      len = 0;
      dp = 0;
      d = 0;
      for (int c = 0; c < 3; c++) begin
         a[c] = joint_pos[j][c];
         ab[c] = (joint_has_child[j] ? joint_tip[j][c] : a[c]) - a[c];
         len += ab[c] * ab[c];
         dp += (p[c] - a[c]) * ab[c];
      end
      t = projection_fraction(dp, len);
      for (int c = 0; c < 3; c++) begin
         n = a[c] + ((ab[c] * t + 32768) >>> 16);
         e = p[c] - n;
         d += e * e;
      end
      if (d > 64'((64'd1 << DIST_W) - 1)) d = (64'd1 << DIST_W) - 1;
      return d;
   endfunction

   // Updates the joint table for a load, or adds the expected binding for a query.
   function automatic void predict_binding(logic op, logic [JIDX_W-1:0] ji,
                                           logic signed [PAR_W-1:0] par, longint p[3]);
      int n;
      int parent;
      longint unsigned d;
      bind_result_type r;
      if (op == OP_LOAD) begin
         parent = par;
         for (int c = 0; c < 3; c++) joint_pos[ji][c] = p[c];
         joint_has_child[ji] = 1'b0;
         if (parent >= 0 && parent < int'(ji) && !joint_has_child[parent]) begin
            for (int c = 0; c < 3; c++) joint_tip[parent][c] = p[c];
            joint_has_child[parent] = 1'b1;
         end
         return;
      end
      n = (searched_count > MAX_JOINTS_DEF) ? MAX_JOINTS_DEF : int'(searched_count);
      r.bone = '0;
      r.dist_sq = '0;
      r.none = (n == 0);
      if (n != 0) begin
         r.dist_sq = '1;
         for (int j = 0; j < n; j++) begin
            d = segment_dist_sq(p, j);
            if (j == 0 || d < r.dist_sq) begin
               r.dist_sq = DIST_W'(d);
               r.bone = JIDX_W'(j);
            end
         end
      end
      pending_binds.insert(pending_binds.size(), r);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         binds_seen++;
         if (pending_binds.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected binding: bone %0d dist %0d",
                                           rsp_bone_index, rsp_distance_sq);
         end else begin
            if (rsp_bone_index !== pending_binds[0].bone ||
                rsp_distance_sq !== pending_binds[0].dist_sq ||
                rsp_no_joints !== pending_binds[0].none) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Binding mismatch: expected bone %0d dist %0d none %0b, %s %0d %0d %0b",
                           pending_binds[0].bone, pending_binds[0].dist_sq, pending_binds[0].none,
                           "got", rsp_bone_index, rsp_distance_sq, rsp_no_joints);
            end
            void'(pending_binds.pop_front());
         end
      end
   end

   task automatic send_item(logic op, logic [JIDX_W-1:0] ji, logic signed [PAR_W-1:0] par,
                            logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                            logic signed [COORD_W-1:0] z);
      longint p[3];
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      start <= 1'b1;
      req_opcode <= op;
      req_joint_index <= ji;
      req_parent_index <= par;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      do @(posedge clock); while (busy);
      p[0] = x;
      p[1] = y;
      p[2] = z;
      predict_binding(op, ji, par, p);
      if (op == OP_LOAD) loads_sent++;
      else queries_sent++;
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending_binds.size() != 0) @(posedge clock);
      repeat (MAX_JOINTS_DEF + 40) @(posedge clock);
   endtask

   task automatic write_joint_count(int unsigned value);
      settle();
      csr_valid <= 1'b1;
      csr_data <= CNT_W'(value);
      do @(posedge clock); while (!csr_ready);
      searched_count = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return COORD_W'($urandom);
         1: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
         default: return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
      endcase
   endfunction

   task automatic send_query();
      send_item(OP_QUERY, JIDX_W'($urandom), PAR_W'($urandom), pick_coord(), pick_coord(),
                pick_coord());
   endtask

   // Loads joints 0..size-1 in ascending order, each with a random earlier parent or none.
   task automatic load_skeleton(int size);
      for (int i = 0; i < size; i++)
         send_item(OP_LOAD, JIDX_W'(i), (i == 0 || $urandom_range(0, 7) == 0) ? -7'sd1 :
                   PAR_W'($urandom_range(0, i - 1)), pick_coord(), pick_coord(), pick_coord());
   endtask

   task automatic test_empty_skeleton();
      send_item(OP_QUERY, '1, '1, 24'sh7fffff, 24'sh800000, 24'sh000000);
      send_item(OP_QUERY, '0, '0, 24'sh800000, 24'sh7fffff, 24'sh7fffff);
   endtask

   task automatic test_load_special_cases();
      load_skeleton(MAX_JOINTS_DEF);
      send_item(OP_LOAD, 6'd5, 7'sd9, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
      send_item(OP_LOAD, 6'd10, 7'sd3, 24'sh800000, 24'sh800000, 24'sh800000);
      send_item(OP_LOAD, 6'd6, -7'sd1, 24'sh000100, 24'sh000000, 24'sh000000);
      send_item(OP_LOAD, 6'd63, 7'sd62, 24'sh7fffff, 24'sh800000, 24'sh7fffff);
      send_item(OP_LOAD, 6'd2, 7'sd2, 24'sh000000, 24'sh000000, 24'sh000000);
      send_item(OP_LOAD, 6'd40, 7'sd1, 24'sh001000, 24'sh000200, 24'sh800000);
   endtask

   task automatic test_count_extremes();
      int unsigned counts[4] = '{1, 3, MAX_JOINTS_DEF, 127};
      foreach (counts[k]) begin
         write_joint_count(counts[k]);
         repeat (3) send_query();
      end
      write_joint_count(0);
      send_query();
   endtask

   task automatic test_random_skeletons();
      int size;
      int unsigned cnt;
      while (loads_sent + queries_sent < 1200) begin
         settle();
         size = $urandom_range(0, 3) == 0 ? MAX_JOINTS_DEF : $urandom_range(1, 12);
         load_skeleton(size);
         repeat ($urandom_range(0, 3))
            send_item(OP_LOAD, JIDX_W'($urandom), PAR_W'($urandom), pick_coord(),
                      pick_coord(), pick_coord());
         case ($urandom_range(0, 7))
            0: cnt = 0;
            1: cnt = $urandom_range(MAX_JOINTS_DEF, 127);
            default: cnt = $urandom_range(1, size);
         endcase
         write_joint_count(cnt);
         repeat ($urandom_range(10, 40)) send_query();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_skeleton();
      test_load_special_cases();
      test_count_extremes();
      test_random_skeletons();
      settle();
      $display("Sent %0d joint loads and %0d vertex queries; %0d bindings checked.",
               loads_sent, queries_sent, binds_seen);
      if (mismatches == 0 && pending_binds.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d bindings missing.", mismatches, pending_binds.size());
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #(12 * 1500000);
      $display("Regression FAIL");
      $finish;
   end
endmodule
